>>> rtl/rwcm_pkg.sv
// Package for the RGBA weighted colour mixer: widths, mode codes,
// divider stage types and the one-bit restoring division step.
// No dependencies.
package rwcm_pkg;

  localparam int unsigned CHAN_N = 4;   // red, green, blue, alpha
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned WT_W   = 34;  // d - w1 - w2 needs two extra bits
  localparam int unsigned SUM_W  = 44;  // signed weighted channel sum
  localparam int unsigned MAG_W  = 43;  // magnitude of the sum
  localparam int unsigned DEN_W  = 32;  // magnitude of the divisor

  localparam logic [1:0] MODE_BLEND = 2'd0;
  localparam logic [1:0] MODE_MIX2  = 2'd1;
  localparam logic [1:0] MODE_MIX3  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;  // unused selector, gives colour 0

  localparam logic [CHAN_W-1:0] FULL_ALPHA = 8'd255;

  // Per-channel divider state
  typedef struct packed {
    logic              neg;
    logic [MAG_W-1:0]  num;
    logic [DEN_W-1:0]  rem;
    logic [CHAN_W-1:0] quo;   // only the low quotient bits are kept
  } chan_t;

  // Payload of one divider stage
  typedef struct packed {
    logic                    zero;
    logic [DEN_W-1:0]        den;
    chan_t [CHAN_N-1:0]      ch;
  } stage_t;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  function automatic chan_t div_step(chan_t c, logic [DEN_W-1:0] den);
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;
    chan_t          r;
    trial = {c.rem, c.num[MAG_W-1]};
    diff  = trial - {1'b0, den};
    fits  = (trial >= {1'b0, den});
    r     = c;
    r.rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    r.num = {c.num[MAG_W-2:0], 1'b0};
    r.quo = {c.quo[CHAN_W-2:0], fits};
    return r;
  endfunction

endpackage

>>> rtl/rgba_weighted_color_mix_core.sv
// RGBA weighted colour mixer, top level: weight set-up, products,
// sums and a bit-per-stage pipelined signed divider. Uses rwcm_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one word per cycle:
//   mode, three packed RGBA8888 colours, two signed weights and a signed
//   divisor. Output channel (out_valid_o / out_ready_i) gives one packed
//   colour per input word, in order.
//   Mode 0 blends colour b over colour a by alpha b, keeping alpha a.
//   Mode 1 mixes a and b, mode 2 mixes a, b and c by the weights over the
//   divisor, quotient truncated toward zero, each channel kept to 8 bits.
//   A zero divisor in modes 1 and 2, and mode 3, give colour 0.
// Pipeline: registers for weight set-up, products, sums and magnitudes,
//   then 43 division stages (one quotient bit per stage for the 43-bit sum
//   magnitude), then the sign/output register; the first of these loads at
//   the accepting edge.
// Throughput: one word per cycle, four channel dividers in parallel.
// Stall: when a result is held and out_ready_i is low, the whole pipeline
//   freezes and in_ready_o drops; nothing is lost or repeated.
// Reset: rst_ni clears all valid bits; the pipeline is empty afterwards.
module rgba_weighted_color_mix_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] color_a_i,
  input  logic [31:0] color_b_i,
  input  logic [31:0] color_c_i,
  input  logic signed [31:0] weight_one_i,
  input  logic signed [31:0] weight_two_i,
  input  logic signed [31:0] divisor_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] color_out_o
);
  import rwcm_pkg::*;

  localparam int unsigned DIV_N = MAG_W;

  logic en;

  // ---------------- stage 1: per-channel weights ----------------
  logic                    v1_q;
  logic                    zero1_q, zero1_d;
  logic signed [31:0]      dv1_q, dv1_d;
  logic [31:0]             ca1_q, cb1_q, cc1_q;
  logic signed [WT_W-1:0]  wa1_q [CHAN_N];
  logic signed [WT_W-1:0]  wb1_q [CHAN_N];
  logic signed [WT_W-1:0]  wc1_q [CHAN_N];
  logic signed [WT_W-1:0]  wa1_d [CHAN_N];
  logic signed [WT_W-1:0]  wb1_d [CHAN_N];
  logic signed [WT_W-1:0]  wc1_d [CHAN_N];

  logic signed [WT_W-1:0]  w1_x, w2_x, d_x;
  logic signed [WT_W-1:0]  a_src;

  assign w1_x  = {{(WT_W-32){weight_one_i[31]}}, weight_one_i};
  assign w2_x  = {{(WT_W-32){weight_two_i[31]}}, weight_two_i};
  assign d_x   = {{(WT_W-32){divisor_i[31]}}, divisor_i};
  assign a_src = {{(WT_W-CHAN_W){1'b0}}, color_b_i[31:24]};

  always_comb begin
    zero1_d = 1'b0;
    dv1_d   = divisor_i;
    for (int k = 0; k < CHAN_N; k++) begin
      wa1_d[k] = '0;
      wb1_d[k] = '0;
      wc1_d[k] = '0;
    end
    case (mode_i)
      MODE_BLEND: begin
        dv1_d = 32'(FULL_ALPHA);
        for (int k = 0; k < CHAN_N - 1; k++) begin
          wa1_d[k] = WT_W'(FULL_ALPHA) - a_src;
          wb1_d[k] = a_src;
        end
        // alpha passes through as a*255/255
        wa1_d[CHAN_N-1] = WT_W'(FULL_ALPHA);
      end
      MODE_MIX2: begin
        zero1_d = (divisor_i == '0);
        for (int k = 0; k < CHAN_N; k++) begin
          wa1_d[k] = d_x - w1_x;
          wb1_d[k] = w1_x;
        end
      end
      MODE_MIX3: begin
        zero1_d = (divisor_i == '0);
        for (int k = 0; k < CHAN_N; k++) begin
          wa1_d[k] = w1_x;
          wb1_d[k] = w2_x;
          wc1_d[k] = d_x - w1_x - w2_x;
        end
      end
      default: begin
        zero1_d = 1'b1;
      end
    endcase
  end

  // ---------------- stage 2: products ----------------
  logic                    v2_q;
  logic                    zero2_q;
  logic signed [31:0]      dv2_q;
  logic signed [SUM_W-1:0] pa2_q [CHAN_N];
  logic signed [SUM_W-1:0] pb2_q [CHAN_N];
  logic signed [SUM_W-1:0] pc2_q [CHAN_N];
  logic signed [SUM_W-1:0] pa2_d [CHAN_N];
  logic signed [SUM_W-1:0] pb2_d [CHAN_N];
  logic signed [SUM_W-1:0] pc2_d [CHAN_N];

  always_comb begin
    for (int k = 0; k < CHAN_N; k++) begin
      pa2_d[k] = $signed({{(SUM_W-CHAN_W){1'b0}}, ca1_q[k*CHAN_W +: CHAN_W]})
               * $signed({{(SUM_W-WT_W){wa1_q[k][WT_W-1]}}, wa1_q[k]});
      pb2_d[k] = $signed({{(SUM_W-CHAN_W){1'b0}}, cb1_q[k*CHAN_W +: CHAN_W]})
               * $signed({{(SUM_W-WT_W){wb1_q[k][WT_W-1]}}, wb1_q[k]});
      pc2_d[k] = $signed({{(SUM_W-CHAN_W){1'b0}}, cc1_q[k*CHAN_W +: CHAN_W]})
               * $signed({{(SUM_W-WT_W){wc1_q[k][WT_W-1]}}, wc1_q[k]});
    end
  end

  // ---------------- stage 3: sums, signs and magnitudes ----------------
  stage_t st0_d;
  logic signed [SUM_W-1:0] sum_w [CHAN_N];
  logic [SUM_W-1:0]        mag_w [CHAN_N];

  always_comb begin
    st0_d.zero = zero2_q;
    st0_d.den  = dv2_q[31] ? (32'd0 - dv2_q) : dv2_q;
    for (int k = 0; k < CHAN_N; k++) begin
      sum_w[k] = pa2_q[k] + pb2_q[k] + pc2_q[k];
      mag_w[k] = sum_w[k][SUM_W-1] ? (SUM_W'(0) - sum_w[k]) : sum_w[k];
      st0_d.ch[k].neg = sum_w[k][SUM_W-1] ^ dv2_q[31];
      st0_d.ch[k].num = mag_w[k][MAG_W-1:0];
      st0_d.ch[k].rem = '0;
      st0_d.ch[k].quo = '0;
    end
  end

  // ---------------- division stages ----------------
  logic   vld_q [DIV_N+1];
  stage_t st_q  [DIV_N+1];

  // ---------------- output register ----------------
  logic        out_valid_q;
  logic [31:0] color_out_q, color_out_d;
  stage_t      last_w;

  assign last_w = st_q[DIV_N];

  always_comb begin
    for (int k = 0; k < CHAN_N; k++) begin
      color_out_d[k*CHAN_W +: CHAN_W] = last_w.ch[k].neg ?
          (CHAN_W'(0) - last_w.ch[k].quo) : last_w.ch[k].quo;
    end
    if (last_w.zero) begin
      color_out_d = '0;
    end
  end

  // whole pipeline moves unless a held result is refused
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign color_out_o = color_out_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i <= DIV_N; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      vld_q[0]    <= v2_q;
      for (int i = 0; i < DIV_N; i++) begin
        vld_q[i+1] <= vld_q[i];
      end
      out_valid_q <= vld_q[DIV_N];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      zero1_q <= zero1_d;
      dv1_q   <= dv1_d;
      ca1_q   <= color_a_i;
      cb1_q   <= color_b_i;
      cc1_q   <= color_c_i;
      zero2_q <= zero1_q;
      dv2_q   <= dv1_q;
      for (int k = 0; k < CHAN_N; k++) begin
        wa1_q[k] <= wa1_d[k];
        wb1_q[k] <= wb1_d[k];
        wc1_q[k] <= wc1_d[k];
        pa2_q[k] <= pa2_d[k];
        pb2_q[k] <= pb2_d[k];
        pc2_q[k] <= pc2_d[k];
      end
      st_q[0] <= st0_d;
      for (int i = 0; i < DIV_N; i++) begin
        st_q[i+1].zero <= st_q[i].zero;
        st_q[i+1].den  <= st_q[i].den;
        for (int k = 0; k < CHAN_N; k++) begin
          st_q[i+1].ch[k] <= div_step(st_q[i].ch[k], st_q[i].den);
        end
      end
      color_out_q <= color_out_d;
    end
  end

`ifndef SYNTH
  // an accepted word enters the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted word did not enter stage 1");

  // a frozen pipeline keeps its last divider stage
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q[DIV_N]) && $stable(out_valid_q))
    else $error("pipeline moved during a stall");

  // a zero-result word gives colour 0
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[DIV_N] && last_w.zero |=> out_valid_o && color_out_o == '0)
    else $error("zero divisor or unused mode did not give colour 0");

  // remainders stay below the divisor after the last step
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DIV_N] && last_w.den != '0 |->
      last_w.ch[0].rem < last_w.den && last_w.ch[1].rem < last_w.den &&
      last_w.ch[2].rem < last_w.den && last_w.ch[3].rem < last_w.den)
    else $error("divider remainder out of range");
`endif

endmodule

>>> sim/rgba_weighted_color_mix_core_tb.sv
// Testbench for rgba_weighted_color_mix_core: directed and random words,
// colour predictor and an in-order scoreboard. Depends on rwcm_pkg and the core.
module rgba_weighted_color_mix_core_tb;
  import rwcm_pkg::*;

  // Expected colour store and checker
  class colour_scoreboard;
    logic [31:0] pending_colours[$];
    int unsigned n_fail;
    int unsigned n_checked;

    function void note_word(logic [31:0] colour);
      pending_colours.push_back(colour);
    endfunction

    function void check_colour(logic [31:0] got);
      logic [31:0] want;
      if (pending_colours.size() == 0) begin
        $error("color_out: unexpected word, actual %h", got);
        n_fail++;
      end else begin
        want = pending_colours.pop_front();
        n_checked++;
        if (want !== got) begin
          $error("color_out: expected %h actual %h", want, got);
          n_fail++;
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        mode_i;
  logic [31:0]       color_a_i;
  logic [31:0]       color_b_i;
  logic [31:0]       color_c_i;
  logic signed [31:0] weight_one_i;
  logic signed [31:0] weight_two_i;
  logic signed [31:0] divisor_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [31:0]       color_out_o;

  colour_scoreboard sb;
  int unsigned cycle_cnt;
  int unsigned n_mode[4];
  bit          rx_calm;
  bit          tx_calm;
  bit          hold_off;

  localparam int unsigned CYCLE_LIMIT = 400000;

  rgba_weighted_color_mix_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Colour predictor: 64-bit signed arithmetic, truncating division
  function automatic logic [31:0] mix_colour(logic [1:0] mode, logic [31:0] ca,
      logic [31:0] cb, logic [31:0] cc, logic signed [31:0] w1,
      logic signed [31:0] w2, logic signed [31:0] dv);
    logic [31:0]        res;
    longint             d;
    longint             s;
    longint             q;
    longint unsigned    x;
    longint unsigned    y;
    longint unsigned    ab;
    res = '0;
    d = dv;
    ab = cb[31:24];
    case (mode)
      MODE_BLEND: begin
        res[31:24] = ca[31:24];
        for (int k = 0; k < 3; k++) begin
          x = ca[8*k +: 8];
          y = cb[8*k +: 8];
          res[8*k +: 8] = 8'((x * (255 - ab) + y * ab) / 255);
        end
      end
      MODE_MIX2, MODE_MIX3: begin
        if (d != 0) begin
          for (int k = 0; k < 4; k++) begin
            if (mode == MODE_MIX2)
              s = longint'(ca[8*k +: 8]) * (d - longint'(w1))
                + longint'(cb[8*k +: 8]) * longint'(w1);
            else
              s = longint'(ca[8*k +: 8]) * longint'(w1)
                + longint'(cb[8*k +: 8]) * longint'(w2)
                + longint'(cc[8*k +: 8]) * (d - longint'(w1) - longint'(w2));
            q = s / d;
            res[8*k +: 8] = q[7:0];
          end
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // Offer one word and wait for acceptance; valid drops only while idling
  task automatic send_word(logic [1:0] m, logic [31:0] a, logic [31:0] b,
      logic [31:0] c, logic [31:0] w1, logic [31:0] w2, logic [31:0] d);
    while (!tx_calm && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    color_a_i    <= a;
    color_b_i    <= b;
    color_c_i    <= c;
    weight_one_i <= w1;
    weight_two_i <= w2;
    divisor_i    <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_word(mix_colour(m, a, b, c, w1, w2, d));
    n_mode[m]++;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(512)) - 256);
      2: return {1'b1, 31'($urandom())};
      default: return $urandom_range(4096);
    endcase
  endfunction

  // Receiver side: random stalls, one long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
      out_ready_i <= rx_calm || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_colour(color_out_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("rgba_weighted_color_mix_core: mismatch");
      $finish;
    end
  end

  initial begin
    logic [31:0] d;
    logic [31:0] w1;
    sb = new();
    cycle_cnt = 0;
    rx_calm = 1'b0;
    tx_calm = 1'b0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = MODE_BLEND;
    color_a_i = '0;
    color_b_i = '0;
    color_c_i = '0;
    weight_one_i = '0;
    weight_two_i = '0;
    divisor_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words: extremes, zero divisor, unused mode, wrapping quotients
    send_word(MODE_BLEND, 32'h0, 32'hFFFF_FFFF, 32'h0, 0, 0, 1);
    send_word(MODE_BLEND, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h0, 0, 0, 1);
    send_word(MODE_BLEND, 32'h1234_5678, 32'h80AB_CDEF, 32'h0, 0, 0, 0);
    send_word(MODE_BLEND, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h0, 0, 0, 0);
    send_word(MODE_MIX2, 32'hFFFF_FFFF, 32'h0, 32'h0, 3, 0, 0);
    send_word(MODE_MIX2, 32'hFF00_FF00, 32'h00FF_00FF, 32'h0, 1, 0, 2);
    send_word(MODE_MIX2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
              32'h8000_0000, 0, 32'h7FFF_FFFF);
    send_word(MODE_MIX2, 32'hFFFF_FFFF, 32'h0, 32'h0,
              32'h7FFF_FFFF, 0, 32'h8000_0000);
    send_word(MODE_MIX2, 32'h0102_0304, 32'hFFFF_FFFF, 32'h0, -5, 0, 3);
    send_word(MODE_MIX2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 0, 0, 32'hFFFF_FFFF);
    send_word(MODE_MIX3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(MODE_MIX3, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(MODE_MIX3, 32'hAABB_CCDD, 32'h1122_3344, 32'h5566_7788, 1, 1, 0);
    send_word(MODE_MIX3, 32'h10, 32'h20, 32'h30, 1, 1, 3);
    send_word(MODE_MIX3, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, -7, 2, -1);
    send_word(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1);
    send_word(MODE_NONE, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);

    // Random words; a calm stretch, then a long receiver hold-off
    for (int i = 0; i < 1750; i++) begin
      tx_calm = (i >= 300 && i < 500);
      rx_calm = tx_calm;
      if (i == 800) hold_off = 1'b1;
      d = rand_weight();
      w1 = rand_weight();
      if ($urandom_range(19) == 0) d = '0;
      send_word(2'($urandom_range(3)), $urandom(), $urandom(), $urandom(),
                w1, rand_weight(), d);
    end
    in_valid_i <= 1'b0;

    // Drain, then allow for pipeline latency
    while (sb.pending_colours.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Covered %0d blend, %0d two-colour, %0d three-colour, %0d unused-mode words;",
             n_mode[MODE_BLEND], n_mode[MODE_MIX2], n_mode[MODE_MIX3], n_mode[MODE_NONE]);
    $display("%0d colours checked, one long output stall included.", sb.n_checked);
    if (sb.n_fail == 0 && sb.pending_colours.size() == 0)
      $display("rgba_weighted_color_mix_core: match");
    else
      $display("rgba_weighted_color_mix_core: mismatch");
    $finish;
  end
endmodule
